// File: hdl/sme_pkg.sv
// shared constants, types and codes for the stack machine execute block
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int VAR_SLOTS   = 64;
    localparam int CALL_DEPTH  = 64;
    localparam int PROG_DEPTH  = 4096;

    localparam int PC_W  = 13;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int FP_W  = $clog2(CALL_DEPTH + 1);
    localparam int FA_W  = $clog2(CALL_DEPTH);
    localparam int VA_W  = $clog2(VAR_SLOTS);
    localparam int POS_W = SP_W + 9;
    localparam int DATA_W = 32;

    localparam int IN_W  = 72;
    localparam int OUT_W = 56;

    typedef enum logic [4:0] {
        CMD_NOP     = 5'd0,
        CMD_PUSH    = 5'd1,
        CMD_ADD     = 5'd2,
        CMD_SUB     = 5'd3,
        CMD_MUL     = 5'd4,
        CMD_DIV     = 5'd5,
        CMD_STORE   = 5'd6,
        CMD_LOAD    = 5'd7,
        CMD_EQ      = 5'd8,
        CMD_GT      = 5'd9,
        CMD_LT      = 5'd10,
        CMD_NE      = 5'd11,
        CMD_JMP     = 5'd12,
        CMD_JZ      = 5'd13,
        CMD_JNZ     = 5'd14,
        CMD_CALL    = 5'd15,
        CMD_LOADARG = 5'd16,
        CMD_RET     = 5'd17,
        CMD_PRINT   = 5'd18
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_NO_LABEL  = 3'd4,
        ST_UNSET_VAR = 3'd5,
        ST_BAD_ARG   = 3'd6,
        ST_FRAME_OVF = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LDARG,
        S_DIV,
        S_FILL,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [PC_W-1:0] ret_pc;
        logic [SP_W-1:0] base;
        logic [7:0]      argc;
    } frame_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage
`default_nettype wire

// File: hdl/stack_machine_execute.sv
// top level: stack machine instruction execute core
//
// channel    | dir | payload
// s_axis     | in  | one decoded instruction request
// m_axis     | out | one result per instruction
// cfg        | in  | program_length write
//
// most instructions go from accept to next accept through read, execute and output
// loadarg adds the S_LDARG state for the second stack memory read
// div waits in its divide state until the bit-serial divider reports done
// ret stays in its fill state while zeroing the stack entries between the old top and the frame base
// reset clears pc, pointers, halt and variable valid bits; memories are not cleared
// a stalled output holds the core in its output state until the result is taken
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    // cmd[4:0] immediate[36:5] var_slot[42:37] target_pc[54:43]
    // target_known[55] arg_count[63:56] arg_index[71:64]
    input  wire  [sme_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    // next_pc[12:0] print_valid[13] print_value[45:14] print_empty[46]
    // status[49:47] halted[50] zero[55:51]
    output logic [sme_pkg::OUT_W-1:0] m_axis_tdata,
    input  wire                       cfg_we,
    input  wire  [12:0]               cfg_wdata
);
    import sme_pkg::*;

    // memories
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] var_mem   [VAR_SLOTS];
    frame_t            frame_mem [CALL_DEPTH];

    fsm_t              state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [FP_W-1:0]   fp_reg, fp_next;
    logic              halt_reg, halt_next;
    logic [12:0]       plen_reg;
    logic [VAR_SLOTS-1:0] vvalid_reg;

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [VA_W-1:0]   slot_reg;
    logic [11:0]       tgt_reg;
    logic              known_reg;
    logic [7:0]        argc_reg;
    logic [7:0]        aidx_reg;

    logic [SP_W-1:0]   fill_reg, fill_next;
    logic [DATA_W-1:0] rv_reg, rv_next;

    status_t           rstat_reg, rstat_next;
    logic              rpv_reg, rpv_next;
    logic [DATA_W-1:0] rpval_reg, rpval_next;
    logic              rpe_reg, rpe_next;

    logic              mv_reg, mv_next;
    logic [OUT_W-1:0]  md_reg, md_next;

    logic [DATA_W-1:0] rd_a_reg, rd_b_reg, var_rd_reg;
    frame_t            frm_rd_reg;
    logic [SA_W-1:0]   rd_addr_a, rd_addr_b;
    logic [VA_W-1:0]   var_addr;

    logic              stk_we;
    logic [SA_W-1:0]   stk_waddr;
    logic [DATA_W-1:0] stk_wdata;
    logic              var_we;
    logic              frm_we;
    frame_t            frm_wdata;

    div_ctl_t          div_ctl;
    logic [DATA_W-1:0] div_q;

    logic              accept;
    logic [PC_W-1:0]   len;
    logic [PC_W-1:0]   npc;
    logic              go;
    logic              fatal;
    status_t           st;
    logic [DATA_W-1:0] top, second, alu;
    logic              sp_full, sp_lt1, sp_lt2;
    logic [POS_W-1:0]  pos;
    logic              arg_bad;
    logic [SP_W-1:0]   cur;

    // input field slices
    logic [4:0]        in_cmd;
    logic [DATA_W-1:0] in_imm;
    logic [5:0]        in_slot;
    logic [11:0]       in_tgt;
    logic              in_known;
    logic [7:0]        in_argc;
    logic [7:0]        in_aidx;

    assign in_cmd   = s_axis_tdata[4:0];
    assign in_imm   = s_axis_tdata[36:5];
    assign in_slot  = s_axis_tdata[42:37];
    assign in_tgt   = s_axis_tdata[54:43];
    assign in_known = s_axis_tdata[55];
    assign in_argc  = s_axis_tdata[63:56];
    assign in_aidx  = s_axis_tdata[71:64];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign len           = (plen_reg > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : plen_reg;

    assign top     = rd_a_reg;
    assign second  = rd_b_reg;
    assign sp_full = sp_reg >= SP_W'(STACK_DEPTH);
    assign sp_lt1  = sp_reg == '0;
    assign sp_lt2  = sp_reg < SP_W'(2);
    assign pos     = POS_W'(frm_rd_reg.base) + POS_W'(aidx_reg);
    assign arg_bad = (aidx_reg >= frm_rd_reg.argc) || (pos >= POS_W'(sp_reg));
    assign cur     = sp_lt1 ? '0 : sp_reg - 1'b1;
    assign rd_addr_b = SA_W'(sp_reg - SP_W'(2));
    assign var_addr  = (state_reg == S_IDLE) ? VA_W'(in_slot) : slot_reg;

    sme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (second),
        .divisor  (top),
        .done     (div_ctl.done),
        .quotient (div_q)
    );

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ADD: alu = second + top;
            CMD_SUB: alu = second - top;
            CMD_MUL: alu = second * top;
            CMD_EQ:  alu = DATA_W'(second == top);
            CMD_GT:  alu = DATA_W'($signed(second) > $signed(top));
            CMD_LT:  alu = DATA_W'($signed(second) < $signed(top));
            default: alu = DATA_W'(second != top);
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        sp_next       = sp_reg;
        fp_next       = fp_reg;
        halt_next     = halt_reg;
        fill_next     = fill_reg;
        rv_next       = rv_reg;
        rstat_next    = rstat_reg;
        rpv_next      = rpv_reg;
        rpval_next    = rpval_reg;
        rpe_next      = rpe_reg;
        mv_next       = mv_reg && !m_axis_tready;
        md_next       = md_reg;
        rd_addr_a     = SA_W'(sp_reg - 1'b1);
        stk_we        = 1'b0;
        stk_waddr     = sp_reg[SA_W-1:0];
        stk_wdata     = '0;
        var_we        = 1'b0;
        frm_we        = 1'b0;
        frm_wdata     = '{ret_pc: pc_reg + 1'b1, base: sp_reg - SP_W'(argc_reg),
                          argc: argc_reg};
        div_ctl.start = 1'b0;
        go            = 1'b0;
        fatal         = 1'b0;
        st            = ST_OK;
        npc           = pc_reg + 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rpv_next   = 1'b0;
                    rpval_next = '0;
                    rpe_next   = 1'b0;
                    rstat_next = ST_OK;
                    if (halt_reg || pc_reg >= len)
                    begin
                        halt_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                priority case (cmd_reg)
                    CMD_PUSH:
                    begin
                        go = 1'b1;
                        if (sp_full)
                        begin
                            fatal = 1'b1;
                            st    = ST_OVERFLOW;
                        end
                        else
                        begin
                            stk_we    = 1'b1;
                            stk_wdata = imm_reg;
                            sp_next   = sp_reg + 1'b1;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_EQ, CMD_GT, CMD_LT, CMD_NE:
                    begin
                        go = 1'b1;
                        if (sp_lt2)
                        begin
                            fatal = 1'b1;
                            st    = ST_UNDERFLOW;
                        end
                        else
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = rd_addr_b;
                            stk_wdata = alu;
                            sp_next   = sp_reg - 1'b1;
                        end
                    end
                    CMD_DIV:
                    begin
                        if (sp_lt2)
                        begin
                            go    = 1'b1;
                            fatal = 1'b1;
                            st    = ST_UNDERFLOW;
                        end
                        else if (top == '0)
                        begin
                            go        = 1'b1;
                            st        = ST_DIV_ZERO;
                            stk_we    = 1'b1;
                            stk_waddr = rd_addr_b;
                            sp_next   = sp_reg - 1'b1;
                        end
                        else
                        begin
                            div_ctl.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    CMD_STORE:
                    begin
                        go = 1'b1;
                        if (sp_lt1)
                        begin
                            fatal = 1'b1;
                            st    = ST_UNDERFLOW;
                        end
                        else
                        begin
                            var_we  = 1'b1;
                            sp_next = sp_reg - 1'b1;
                        end
                    end
                    CMD_LOAD:
                    begin
                        go = 1'b1;
                        if (sp_full)
                        begin
                            fatal = 1'b1;
                            st    = ST_OVERFLOW;
                        end
                        else
                        begin
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            if (vvalid_reg[slot_reg])
                                stk_wdata = var_rd_reg;
                            else
                                st = ST_UNSET_VAR;
                        end
                    end
                    CMD_JMP:
                    begin
                        go = 1'b1;
                        if (known_reg)
                            npc = PC_W'(tgt_reg);
                        else
                            st = ST_NO_LABEL;
                    end
                    CMD_JZ, CMD_JNZ:
                    begin
                        go = 1'b1;
                        if (sp_lt1)
                        begin
                            fatal = 1'b1;
                            st    = ST_UNDERFLOW;
                        end
                        else
                        begin
                            sp_next = sp_reg - 1'b1;
                            if ((top == '0) == (cmd_reg == CMD_JZ))
                            begin
                                if (known_reg)
                                    npc = PC_W'(tgt_reg);
                                else
                                    st = ST_NO_LABEL;
                            end
                        end
                    end
                    CMD_CALL:
                    begin
                        go = 1'b1;
                        if (POS_W'(argc_reg) > POS_W'(sp_reg))
                        begin
                            fatal = 1'b1;
                            st    = ST_UNDERFLOW;
                        end
                        else if (fp_reg >= FP_W'(CALL_DEPTH))
                        begin
                            fatal = 1'b1;
                            st    = ST_FRAME_OVF;
                        end
                        else
                        begin
                            frm_we  = 1'b1;
                            fp_next = fp_reg + 1'b1;
                            if (known_reg)
                                npc = PC_W'(tgt_reg);
                            else
                                st = ST_NO_LABEL;
                        end
                    end
                    CMD_LOADARG:
                    begin
                        if (sp_full)
                        begin
                            go    = 1'b1;
                            fatal = 1'b1;
                            st    = ST_OVERFLOW;
                        end
                        else if (fp_reg == '0 || arg_bad)
                        begin
                            go      = 1'b1;
                            st      = ST_BAD_ARG;
                            stk_we  = 1'b1;
                            sp_next = sp_reg + 1'b1;
                        end
                        else
                        begin
                            // second read: the argument itself
                            rd_addr_a  = pos[SA_W-1:0];
                            state_next = S_LDARG;
                        end
                    end
                    CMD_RET:
                    begin
                        if (fp_reg == '0)
                        begin
                            go  = 1'b1;
                            npc = len;
                        end
                        else if (frm_rd_reg.base >= SP_W'(STACK_DEPTH))
                        begin
                            go    = 1'b1;
                            fatal = 1'b1;
                            st    = ST_OVERFLOW;
                        end
                        else
                        begin
                            fill_next  = cur;
                            rv_next    = sp_lt1 ? '0 : top;
                            state_next = S_FILL;
                        end
                    end
                    CMD_PRINT:
                    begin
                        go       = 1'b1;
                        rpv_next = 1'b1;
                        if (sp_lt1)
                            rpe_next = 1'b1;
                        else
                            rpval_next = top;
                    end
                    default:
                    begin
                        go = 1'b1;
                    end
                endcase
            end
            S_LDARG:
            begin
                go        = 1'b1;
                stk_we    = 1'b1;
                stk_wdata = rd_a_reg;
                sp_next   = sp_reg + 1'b1;
            end
            S_DIV:
            begin
                if (div_ctl.done)
                begin
                    go        = 1'b1;
                    stk_we    = 1'b1;
                    stk_waddr = rd_addr_b;
                    stk_wdata = div_q;
                    sp_next   = sp_reg - 1'b1;
                end
            end
            S_FILL:
            begin
                stk_we = 1'b1;
                // zero the entries a return exposes, then place the return value
                if (fill_reg < frm_rd_reg.base)
                begin
                    stk_waddr = fill_reg[SA_W-1:0];
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    go        = 1'b1;
                    stk_waddr = frm_rd_reg.base[SA_W-1:0];
                    stk_wdata = rv_reg;
                    sp_next   = frm_rd_reg.base + 1'b1;
                    fp_next   = fp_reg - 1'b1;
                    npc       = frm_rd_reg.ret_pc;
                end
            end
            S_DONE:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {5'd0, halt_reg, rstat_reg, rpe_reg, rpval_reg,
                                  rpv_reg, pc_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go)
        begin
            state_next = S_DONE;
            rstat_next = st;
            if (fatal)
            begin
                halt_next = 1'b1;
                sp_next   = sp_reg;
                fp_next   = fp_reg;
            end
            else
            begin
                pc_next = npc;
                if (npc >= len)
                    halt_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            sp_reg     <= '0;
            fp_reg     <= '0;
            halt_reg   <= 1'b0;
            plen_reg   <= 13'd4096;
            vvalid_reg <= '0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            fp_reg    <= fp_next;
            halt_reg  <= halt_next;
            mv_reg    <= mv_next;
            if (cfg_we)
                plen_reg <= cfg_wdata;
            if (var_we)
                vvalid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(in_cmd);
            imm_reg   <= in_imm;
            slot_reg  <= VA_W'(in_slot);
            tgt_reg   <= in_tgt;
            known_reg <= in_known;
            argc_reg  <= in_argc;
            aidx_reg  <= in_aidx;
        end
        fill_reg  <= fill_next;
        rv_reg    <= rv_next;
        rstat_reg <= rstat_next;
        rpv_reg   <= rpv_next;
        rpval_reg <= rpval_next;
        rpe_reg   <= rpe_next;
        md_reg    <= md_next;
    end

    // operand stack: one write, two reads
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        rd_a_reg <= stack_mem[rd_addr_a];
        rd_b_reg <= stack_mem[rd_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (var_we)
            var_mem[slot_reg] <= top;
        var_rd_reg <= var_mem[var_addr];
    end

    always_ff @(posedge clk)
    begin
        if (frm_we)
            frame_mem[fp_reg[FA_W-1:0]] <= frm_wdata;
        frm_rd_reg <= frame_mem[FA_W'(fp_reg - 1'b1)];
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_fp_range: assert property (@(posedge clk) disable iff (!rst_n)
        fp_reg <= FP_W'(CALL_DEPTH))
        else $error("frame pointer beyond depth");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt cleared without reset");

    a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

endmodule
`default_nettype wire

// File: hdl/sme_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
`default_nettype none
module sme_div (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [sme_pkg::DATA_W-1:0]  dividend,
    input  wire  [sme_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [sme_pkg::DATA_W-1:0]  quotient
);
    import sme_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        diff      = rem_sh - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            // work on magnitudes, fix the sign at the end
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule
`default_nettype wire
